>>> sv/sdcr_pkg.sv
package sdcr_pkg;

	localparam int CmdW  = 6;
	localparam int WordW = 32;
	localparam int StW   = 4;
	localparam int BlkW  = 3;

	// card states
	localparam logic [StW-1:0] ST_IDLE     = 4'd0;
	localparam logic [StW-1:0] ST_IDENT    = 4'd2;
	localparam logic [StW-1:0] ST_STANDBY  = 4'd3;
	localparam logic [StW-1:0] ST_TRANSFER = 4'd4;
	localparam logic [StW-1:0] ST_INVALID  = 4'd15;

	// command indexes
	localparam logic [CmdW-1:0] CMD_GO_IDLE     = 6'd0;
	localparam logic [CmdW-1:0] CMD_ALL_CID     = 6'd2;
	localparam logic [CmdW-1:0] CMD_SEND_RCA    = 6'd3;
	localparam logic [CmdW-1:0] CMD_IO_OCR      = 6'd5;
	localparam logic [CmdW-1:0] CMD_SWITCH      = 6'd6;
	localparam logic [CmdW-1:0] CMD_SELECT      = 6'd7;
	localparam logic [CmdW-1:0] CMD_IF_COND     = 6'd8;
	localparam logic [CmdW-1:0] CMD_SEND_CSD    = 6'd9;
	localparam logic [CmdW-1:0] CMD_STATUS      = 6'd13;
	localparam logic [CmdW-1:0] CMD_BLOCKLEN    = 6'd16;
	localparam logic [CmdW-1:0] CMD_APP         = 6'd55;

	// app command indexes
	localparam logic [CmdW-1:0] ACMD_BUS_WIDTH  = 6'd6;
	localparam logic [CmdW-1:0] ACMD_SD_STATUS  = 6'd13;
	localparam logic [CmdW-1:0] ACMD_OP_COND    = 6'd41;
	localparam logic [CmdW-1:0] ACMD_CLR_DETECT = 6'd42;
	localparam logic [CmdW-1:0] ACMD_SEND_SCR   = 6'd51;

	localparam logic [WordW-1:0] APP_FLAG     = 32'h0000_0020;
	localparam logic [WordW-1:0] INIT_DONE    = 32'h8000_0000;
	localparam logic [WordW-1:0] CCS_HIGH_CAP = 32'h4000_0000;
	localparam logic [WordW-1:0] OCR_VOLTAGES = 32'h00FF_8000;
	localparam logic [WordW-1:0] CARD_RCA     = 32'h0000_AAAA;
	localparam logic [3:0]       GROUP1_SDR   = 4'h1;

	// data block tags
	localparam logic [BlkW-1:0] BLK_NONE   = 3'd0;
	localparam logic [BlkW-1:0] BLK_SSR    = 3'd1;
	localparam logic [BlkW-1:0] BLK_SCR    = 3'd2;
	localparam logic [BlkW-1:0] BLK_SWITCH = 3'd3;
	localparam logic [BlkW-1:0] BLK_CID    = 3'd4;
	localparam logic [BlkW-1:0] BLK_CSD    = 3'd5;

	typedef struct packed {
		logic [StW-1:0] card_state;
		logic           ready_for_data;
		logic           crc_error;
		logic           illegal_cmd;
		logic           init_seen;
	} card_t;

	function automatic logic [WordW-1:0] status_word(input logic [StW-1:0] st,
			input logic rdy);
		status_word = {19'd0, st, rdy, 8'd0};
	endfunction

endpackage

>>> sv/sdcr_if.sv
interface sdcr_cmd_if import sdcr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CmdW-1:0]  command;
	logic [WordW-1:0] argument;
	logic             has_second;
	logic [CmdW-1:0]  second_command;

	modport source(output valid, command, argument, has_second, second_command,
		input ready);
	modport sink(input valid, command, argument, has_second, second_command,
		output ready);
endinterface

interface sdcr_rsp_if import sdcr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             status;
	logic             first_complete;
	logic [WordW-1:0] first_response;
	logic             second_complete;
	logic [WordW-1:0] second_response;
	logic [BlkW-1:0]  data_block;

	modport source(output valid, status, first_complete, first_response,
		second_complete, second_response, data_block, input ready);
	modport sink(input valid, status, first_complete, first_response,
		second_complete, second_response, data_block, output ready);
endinterface

>>> sv/sd_card_command_responder.sv
// Pipeline: the command is captured in the input register and decoded into the result
// register, which drives the response channel.
// Throughput: one command per cycle while the sink takes responses; the result register frees
// the input stage when it is empty or when its response is taken, so commands stream with no bubbles.
// Reset (arst_n low, asynchronous): card state invalid (15), ready, CRC-error, illegal and
// init-seen flags cleared, both pipeline stages empty.
module sd_card_command_responder import sdcr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sdcr_cmd_if.sink     cmd,
	sdcr_rsp_if.source   rsp
);

	// ---------------------------------------------------------------
	// Stage 1: captured command
	// ---------------------------------------------------------------
	logic             valid_s1;
	logic [CmdW-1:0]  command_s1;
	logic [WordW-1:0] argument_s1;
	logic             has_second_s1;
	logic [CmdW-1:0]  second_command_s1;

	// card state, updated when the stage-1 command moves to the result register
	card_t card_q;
	card_t card_nxt;

	// decoded result
	logic             status_d;
	logic             c1_d;
	logic [WordW-1:0] r1_d;
	logic             c2_d;
	logic [WordW-1:0] r2_d;
	logic [BlkW-1:0]  blk_d;

	logic out_free;   // result register can take a new item this cycle
	logic adv_s1;     // stage-1 item moves to the result register

	assign out_free  = !rsp.valid || rsp.ready;
	assign adv_s1    = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1        <= cmd.command;
			argument_s1       <= cmd.argument;
			has_second_s1     <= cmd.has_second;
			second_command_s1 <= cmd.second_command;
		end
	end

	// ---------------------------------------------------------------
	// Command decode. Responses use the state before the command and the
	// ready bit as already set by the command itself.
	// ---------------------------------------------------------------
	always_comb begin
		logic app_low;
		logic acmd_ok;
		app_low  = (card_q.card_state == ST_INVALID) || (card_q.card_state == ST_IDLE);
		acmd_ok  = has_second_s1 && ((second_command_s1 == ACMD_CLR_DETECT) ||
			(second_command_s1 == ACMD_SD_STATUS) || (second_command_s1 == ACMD_SEND_SCR) ||
			(second_command_s1 == ACMD_BUS_WIDTH));
		card_nxt = card_q;
		status_d = 1'b0;
		c1_d     = 1'b0;
		r1_d     = '0;
		c2_d     = 1'b0;
		r2_d     = '0;
		blk_d    = BLK_NONE;
		unique case (command_s1)
			CMD_GO_IDLE: begin
				c1_d     = 1'b1;
				card_nxt = '{card_state: ST_IDLE, default: 1'b0};
			end
			CMD_IF_COND: begin
				c1_d                = 1'b1;
				r1_d                = argument_s1;
				card_nxt.card_state = ST_IDLE;
			end
			CMD_IO_OCR: begin
				status_d             = 1'b1;
				card_nxt.crc_error   = 1'b1;
				card_nxt.illegal_cmd = 1'b1;
				card_nxt.card_state  = ST_INVALID;
			end
			CMD_APP: begin
				card_nxt.ready_for_data = 1'b1;
				c1_d = 1'b1;
				if (app_low) begin
					r1_d = {8'd0, card_q.crc_error, card_q.illegal_cmd, 22'd0} |
						status_word(card_q.card_state, 1'b1) | APP_FLAG;
					if (has_second_s1 && second_command_s1 == ACMD_OP_COND) begin
						c2_d = 1'b1;
						r2_d = OCR_VOLTAGES | CCS_HIGH_CAP |
							(card_q.init_seen ? INIT_DONE : '0);
						card_nxt.crc_error   = 1'b0;
						card_nxt.illegal_cmd = 1'b0;
						card_nxt.init_seen   = 1'b1;
						card_nxt.card_state  = ST_IDLE;
					end else begin
						status_d = 1'b1;
					end
				end else begin
					r1_d = status_word(card_q.card_state, 1'b1) | APP_FLAG;
					if (acmd_ok) begin
						c2_d = 1'b1;
						r2_d = r1_d;
						if (second_command_s1 == ACMD_SD_STATUS) begin
							blk_d = BLK_SSR;
						end else if (second_command_s1 == ACMD_SEND_SCR) begin
							blk_d = BLK_SCR;
						end
						card_nxt.card_state = ST_TRANSFER;
					end else begin
						status_d = 1'b1;
					end
				end
			end
			CMD_ALL_CID: begin
				c1_d                = 1'b1;
				blk_d               = BLK_CID;
				card_nxt.card_state = ST_IDENT;
			end
			CMD_SEND_RCA: begin
				card_nxt.ready_for_data = 1'b1;
				c1_d = 1'b1;
				r1_d = CARD_RCA | status_word(card_q.card_state, 1'b1) | APP_FLAG;
				card_nxt.card_state = ST_STANDBY;
			end
			CMD_SWITCH: begin
				if (argument_s1[3:0] == GROUP1_SDR) begin
					card_nxt.ready_for_data = 1'b1;
					c1_d  = 1'b1;
					r1_d  = status_word(card_q.card_state, 1'b1);
					blk_d = BLK_SWITCH;
					card_nxt.card_state = ST_TRANSFER;
				end else begin
					status_d = 1'b1;
				end
			end
			CMD_SELECT, CMD_BLOCKLEN: begin
				card_nxt.ready_for_data = 1'b1;
				c1_d = 1'b1;
				r1_d = status_word(card_q.card_state, 1'b1);
				card_nxt.card_state = ST_TRANSFER;
			end
			CMD_SEND_CSD: begin
				c1_d                = 1'b1;
				blk_d               = BLK_CSD;
				card_nxt.card_state = ST_STANDBY;
			end
			CMD_STATUS: begin
				c1_d = 1'b1;
				r1_d = status_word(card_q.card_state, card_q.ready_for_data);
				card_nxt.card_state = ST_TRANSFER;
			end
			default: begin
				status_d = 1'b1;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Card state and result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			card_q    <= '{card_state: ST_INVALID, default: 1'b0};
			rsp.valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				card_q <= card_nxt;
			end
			if (out_free) begin
				rsp.valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp.status          <= status_d;
			rsp.first_complete  <= c1_d;
			rsp.first_response  <= r1_d;
			rsp.second_complete <= c2_d;
			rsp.second_response <= r2_d;
			rsp.data_block      <= blk_d;
		end
	end

`ifndef SYNTHESIS
	// only the defined card states are ever reached
	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		card_q.card_state == ST_IDLE || card_q.card_state == ST_IDENT ||
		card_q.card_state == ST_STANDBY || card_q.card_state == ST_TRANSFER ||
		card_q.card_state == ST_INVALID)
		else $error("card state left the defined set");

	// a completed app command never reports a rejected item
	a_second_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.second_complete |-> !rsp.status && rsp.first_complete)
		else $error("app command complete with error status");

	// no transfer is taken while both stages are full and the output stalls
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp.valid && !rsp.ready |-> !cmd.ready)
		else $error("command taken while pipeline is full");

	// the card state changes only when an item leaves stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(card_q))
		else $error("card state changed without a command");
`endif

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sdcr_pkg::*;

	// Run shape: a short directed walk, then random traffic in three pacing phases.
	localparam int RANDOM_CMDS  = 1600;
	localparam int DRAIN_CYCLES = 8;        // pipeline is two deep, leave some slack
	localparam int CYCLE_LIMIT  = 200_000;  // watchdog bound for a hung run

	// Pacing per phase: percent of cycles the host holds off / the sink stalls.
	localparam int SEND_IDLE [3] = '{12, 62, 0};
	localparam int RECV_IDLE [3] = '{62, 12, 0};

	// Command indexes the card does not know, used for rejection cases.
	localparam logic [CmdW-1:0] UNKNOWN_CMD  = 6'd63;
	localparam logic [CmdW-1:0] UNKNOWN_LOW  = 6'd1;
	localparam logic [CmdW-1:0] UNKNOWN_ACMD = 6'd63;

	// Command pools for the random part.
	localparam logic [CmdW-1:0] HOST_CMDS [11] = '{CMD_GO_IDLE, CMD_ALL_CID, CMD_SEND_RCA,
		CMD_IO_OCR, CMD_SWITCH, CMD_SELECT, CMD_IF_COND, CMD_SEND_CSD, CMD_STATUS,
		CMD_BLOCKLEN, CMD_APP};
	localparam logic [CmdW-1:0] APP_CMDS [5] = '{ACMD_BUS_WIDTH, ACMD_SD_STATUS,
		ACMD_OP_COND, ACMD_CLR_DETECT, ACMD_SEND_SCR};

	// One host command transfer (first command plus optional app command).
	typedef struct packed {
		logic [CmdW-1:0]  command;
		logic [WordW-1:0] argument;
		logic             has_second;
		logic [CmdW-1:0]  second_command;
	} host_cmd_t;

	// One response transfer, field for field as on the rsp channel.
	typedef struct packed {
		logic             status;
		logic             first_complete;
		logic [WordW-1:0] first_response;
		logic             second_complete;
		logic [WordW-1:0] second_response;
		logic [BlkW-1:0]  data_block;
	} card_reply_t;

	// Directed row: when fixed is set, want is the hand-written response and the
	// predictor only tracks the card state; otherwise the predictor supplies it.
	typedef struct packed {
		host_cmd_t   cmd;
		logic        fixed;
		card_reply_t want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;

	sdcr_cmd_if cmd_if();
	sdcr_rsp_if rsp_if();

	sd_card_command_responder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	// Predicted card state, mirrors what the block should hold after reset.
	card_t       card_now = '{ST_INVALID, 1'b0, 1'b0, 1'b0, 1'b0};
	card_reply_t replies_due[$];
	dir_row_t    directed_rows[$];

	int send_idle_pct;
	int recv_idle_pct;
	int cmds_sent;
	int replies_seen;
	int acmds_done;
	int mismatches;
	int cycle_count;

	always begin
		clk = 1'b0;
		#10ns;
		clk = 1'b1;
		#10ns;
	end

	// R1-style card status bits: state in 12:9, ready in 8.
	function automatic logic [WordW-1:0] card_word();
		return (WordW'(card_now.card_state) << 9) | (WordW'(card_now.ready_for_data) << 8);
	endfunction

	// Predict the response to one command and advance the card state.
	// Every response word uses the state from before the command but the ready
	// bit as the command itself leaves it, so ready is always updated first.
	function automatic card_reply_t respond_to(host_cmd_t c);
		card_reply_t r;
		r = '0;
		case (c.command)
			CMD_GO_IDLE: begin
				r.first_complete = 1'b1;
				card_now = '{ST_IDLE, 1'b0, 1'b0, 1'b0, 1'b0};
			end
			CMD_IF_COND: begin
				// voltage check: argument comes back as is
				r.first_complete = 1'b1;
				r.first_response = c.argument;
				card_now.card_state = ST_IDLE;
			end
			CMD_IO_OCR: begin
				// not an SDIO card: reject and fall into the invalid state
				r.status = 1'b1;
				card_now.crc_error = 1'b1;
				card_now.illegal_cmd = 1'b1;
				card_now.card_state = ST_INVALID;
			end
			CMD_APP: begin
				card_now.ready_for_data = 1'b1;
				r.first_complete = 1'b1;
				if (card_now.card_state == ST_INVALID || card_now.card_state == ST_IDLE) begin
					// before init only ACMD41 is taken; error flags show in the word
					r.first_response = card_word() | APP_FLAG |
						(WordW'(card_now.crc_error) << 23) |
						(WordW'(card_now.illegal_cmd) << 22);
					if (c.has_second && c.second_command == ACMD_OP_COND) begin
						r.second_complete = 1'b1;
						r.second_response = OCR_VOLTAGES | CCS_HIGH_CAP |
							(card_now.init_seen ? INIT_DONE : '0);
						card_now.crc_error = 1'b0;
						card_now.illegal_cmd = 1'b0;
						card_now.init_seen = 1'b1;
						card_now.card_state = ST_IDLE;
					end else begin
						r.status = 1'b1;
					end
				end else begin
					r.first_response = card_word() | APP_FLAG;
					if (c.has_second && (c.second_command == ACMD_CLR_DETECT ||
							c.second_command == ACMD_SD_STATUS ||
							c.second_command == ACMD_SEND_SCR ||
							c.second_command == ACMD_BUS_WIDTH)) begin
						r.second_complete = 1'b1;
						r.second_response = r.first_response;
						if (c.second_command == ACMD_SD_STATUS)
							r.data_block = BLK_SSR;
						else if (c.second_command == ACMD_SEND_SCR)
							r.data_block = BLK_SCR;
						card_now.card_state = ST_TRANSFER;
					end else begin
						r.status = 1'b1;
					end
				end
			end
			CMD_ALL_CID: begin
				r.first_complete = 1'b1;
				r.data_block = BLK_CID;
				card_now.card_state = ST_IDENT;
			end
			CMD_SEND_RCA: begin
				card_now.ready_for_data = 1'b1;
				r.first_complete = 1'b1;
				r.first_response = CARD_RCA | card_word() | APP_FLAG;
				card_now.card_state = ST_STANDBY;
			end
			CMD_SWITCH: begin
				// only the group-1 high-speed switch is honored
				if (c.argument[3:0] == GROUP1_SDR) begin
					card_now.ready_for_data = 1'b1;
					r.first_complete = 1'b1;
					r.first_response = card_word();
					r.data_block = BLK_SWITCH;
					card_now.card_state = ST_TRANSFER;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_SELECT, CMD_BLOCKLEN: begin
				card_now.ready_for_data = 1'b1;
				r.first_complete = 1'b1;
				r.first_response = card_word();
				card_now.card_state = ST_TRANSFER;
			end
			CMD_SEND_CSD: begin
				r.first_complete = 1'b1;
				r.data_block = BLK_CSD;
				card_now.card_state = ST_STANDBY;
			end
			CMD_STATUS: begin
				r.first_complete = 1'b1;
				r.first_response = card_word();
				card_now.card_state = ST_TRANSFER;
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic dir_row_t row(logic [CmdW-1:0] cmd, logic [WordW-1:0] arg = '0,
			logic has2 = 1'b0, logic [CmdW-1:0] acmd = '0, logic fixed = 1'b0,
			card_reply_t want = '0);
		return '{'{cmd, arg, has2, acmd}, fixed, want};
	endfunction

	// Random content around a chosen index. CMD55 mostly carries its app command;
	// CMD6 mostly asks for the one switch the card accepts.
	function automatic host_cmd_t with_args(logic [CmdW-1:0] cmd, logic [CmdW-1:0] acmd);
		host_cmd_t c;
		c.command = cmd;
		c.argument = $urandom();
		c.has_second = (cmd == CMD_APP) ? ($urandom_range(0, 9) != 0) :
			1'($urandom_range(0, 1));
		c.second_command = acmd;
		if (cmd == CMD_SWITCH && $urandom_range(0, 2) != 0)
			c.argument[3:0] = GROUP1_SDR;
		return c;
	endfunction

	function automatic logic [CmdW-1:0] pick_acmd();
		if ($urandom_range(0, 4) != 0)
			return APP_CMDS[$urandom_range(0, 4)];
		return CmdW'($urandom());
	endfunction

	// Drive one command, hold it until the block takes the transfer, then log
	// the expected response. Random host hold-off may follow each transfer.
	task automatic push_cmd(host_cmd_t c, logic fixed = 1'b0, card_reply_t want = '0);
		card_reply_t predicted;
		cmd_if.valid <= 1'b1;
		cmd_if.command <= c.command;
		cmd_if.argument <= c.argument;
		cmd_if.has_second <= c.has_second;
		cmd_if.second_command <= c.second_command;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		predicted = respond_to(c);
		replies_due.push_back(fixed ? want : predicted);
		cmds_sent++;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Well-formed init flow with random content, then some use of the card.
	task automatic bring_up_and_use();
		push_cmd(with_args(CMD_GO_IDLE, CmdW'($urandom())));
		push_cmd(with_args(CMD_IF_COND, CmdW'($urandom())));
		repeat ($urandom_range(1, 3))
			push_cmd(with_args(CMD_APP, ACMD_OP_COND));
		push_cmd(with_args(CMD_ALL_CID, CmdW'($urandom())));
		push_cmd(with_args(CMD_SEND_RCA, CmdW'($urandom())));
		push_cmd(with_args(CMD_SEND_CSD, CmdW'($urandom())));
		push_cmd(with_args(CMD_SELECT, CmdW'($urandom())));
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1))
				push_cmd(with_args(CMD_APP, pick_acmd()));
			else
				push_cmd(with_args(HOST_CMDS[$urandom_range(0, 10)], CmdW'($urandom())));
		end
	endtask

	task automatic check_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	// Response sink: random stalls per the current phase, held low in reset.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Response checker: each transfer against the oldest expectation.
	always @(posedge clk) begin
		card_reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			replies_seen++;
			if (rsp_if.second_complete)
				acmds_done++;
			if (replies_due.size() == 0) begin
				mismatches++;
				$display("%0t: response with none expected, expected nothing, got %h/%h",
					$time, rsp_if.first_response, rsp_if.second_response);
			end else begin
				want = replies_due.pop_front();
				check_field("status", want.status, rsp_if.status);
				check_field("first_complete", want.first_complete, rsp_if.first_complete);
				check_field("first_response", want.first_response, rsp_if.first_response);
				check_field("second_complete", want.second_complete, rsp_if.second_complete);
				check_field("second_response", want.second_response, rsp_if.second_response);
				check_field("data_block", want.data_block, rsp_if.data_block);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses still due", $time, replies_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int phase;
		int stop_at;
		int pick;

		cmd_if.valid <= 1'b0;
		cmd_if.command <= '0;
		cmd_if.argument <= '0;
		cmd_if.has_second <= 1'b0;
		cmd_if.second_command <= '0;
		send_idle_pct = SEND_IDLE[0];
		recv_idle_pct = RECV_IDLE[0];

		// Directed walk: init from reset, rejections, every command and app
		// command, argument and index extremes. Typed responses only where obvious.
		directed_rows = '{
			// ACMD41 straight out of reset: invalid state, ready now set
			row(CMD_APP, '0, 1'b1, ACMD_OP_COND, 1'b1,
				card_reply_t'{1'b0, 1'b1, 32'h0000_1F20, 1'b1,
				OCR_VOLTAGES | CCS_HIGH_CAP, BLK_NONE}),
			// second ACMD41 reports init done
			row(CMD_APP, 32'hFFFF_FFFF, 1'b1, ACMD_OP_COND, 1'b1,
				card_reply_t'{1'b0, 1'b1, 32'h0000_0120, 1'b1,
				INIT_DONE | OCR_VOLTAGES | CCS_HIGH_CAP, BLK_NONE}),
			// CMD5 is refused and raises both error flags
			row(CMD_IO_OCR, 32'hFFFF_FFFF, 1'b1, UNKNOWN_ACMD, 1'b1,
				card_reply_t'{1'b1, 1'b0, '0, 1'b0, '0, BLK_NONE}),
			// CMD55 alone in invalid state: flags visible, still completes
			row(CMD_APP, '0, 1'b0, ACMD_OP_COND, 1'b1,
				card_reply_t'{1'b1, 1'b1, 32'h00C0_1F20, 1'b0, '0, BLK_NONE}),
			// CMD0 with a stray app command attached: app part ignored
			row(CMD_GO_IDLE, 32'hFFFF_FFFF, 1'b1, ACMD_OP_COND, 1'b1,
				card_reply_t'{1'b0, 1'b1, '0, 1'b0, '0, BLK_NONE}),
			row(CMD_IF_COND, 32'hFFFF_FFFF, 1'b0, '0, 1'b1,
				card_reply_t'{1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, '0, BLK_NONE}),
			row(CMD_IF_COND, '0, 1'b0, '0, 1'b1,
				card_reply_t'{1'b0, 1'b1, '0, 1'b0, '0, BLK_NONE}),
			// unsupported app command in idle
			row(CMD_APP, '0, 1'b1, UNKNOWN_ACMD, 1'b1,
				card_reply_t'{1'b1, 1'b1, 32'h0000_0120, 1'b0, '0, BLK_NONE}),
			row(CMD_ALL_CID, 32'h5A5A_A5A5, 1'b0, '0, 1'b1,
				card_reply_t'{1'b0, 1'b1, '0, 1'b0, '0, BLK_CID}),
			row(CMD_SEND_RCA),
			row(CMD_SEND_CSD),
			row(CMD_APP, '0, 1'b1, ACMD_SD_STATUS),
			row(CMD_APP, '0, 1'b1, ACMD_SEND_SCR),
			row(CMD_APP, '0, 1'b1, ACMD_CLR_DETECT),
			row(CMD_APP, '0, 1'b1, ACMD_BUS_WIDTH),
			// ACMD41 once past idle is not accepted
			row(CMD_APP, '0, 1'b1, ACMD_OP_COND),
			row(CMD_APP, '0, 1'b0, ACMD_SEND_SCR),
			row(CMD_SWITCH, 32'h0000_0001),
			row(CMD_SWITCH, 32'hFFFF_FFF1),
			// switch to anything but group-1 function 1 is refused
			row(CMD_SWITCH, 32'hFFFF_FFFF, 1'b0, '0, 1'b1,
				card_reply_t'{1'b1, 1'b0, '0, 1'b0, '0, BLK_NONE}),
			row(CMD_SELECT),
			row(CMD_BLOCKLEN, 32'hFFFF_FFFF),
			row(UNKNOWN_CMD, 32'hFFFF_FFFF, 1'b1, ACMD_OP_COND, 1'b1,
				card_reply_t'{1'b1, 1'b0, '0, 1'b0, '0, BLK_NONE}),
			row(UNKNOWN_LOW, '0, 1'b0, '0, 1'b1,
				card_reply_t'{1'b1, 1'b0, '0, 1'b0, '0, BLK_NONE}),
			row(CMD_STATUS)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_cmd(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want);

		// Random part: mostly init flows and legal commands, the rest raw noise.
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = SEND_IDLE[phase];
			recv_idle_pct = RECV_IDLE[phase];
			stop_at = cmds_sent + RANDOM_CMDS / 3;
			while (cmds_sent < stop_at) begin
				pick = $urandom_range(0, 99);
				if (pick < 35)
					bring_up_and_use();
				else if (pick < 75)
					push_cmd(with_args(HOST_CMDS[$urandom_range(0, 10)], pick_acmd()));
				else
					push_cmd(with_args(CmdW'($urandom()), CmdW'($urandom())));
			end
		end
		cmd_if.valid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d commands, %0d responses checked, %0d app commands completed,",
			cmds_sent, replies_seen, acmds_done);
		$display("under host-heavy, sink-heavy and unthrottled pacing; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sd_card_command_responder.f
sv/sdcr_pkg.sv
sv/sdcr_if.sv
sv/sd_card_command_responder.sv
tb/testbench.sv
